// ===== hdl/ordered_array_list_engine_unit_defines.svh =====
// Assertion macros used by the list engine unit.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ORDERED_ARRAY_LIST_ENGINE_UNIT_DEFINES_SVH
`define ORDERED_ARRAY_LIST_ENGINE_UNIT_DEFINES_SVH

// The condition holds at every clock edge.
`define OLAE_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// The consequence holds at the edge after the antecedent.
`define OLAE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/olae_pkg.sv =====
package olae_pkg;

  // List geometry and field widths.
  localparam int CAPACITY   = 64;
  localparam int DATA_W     = 32;
  localparam int KIND_W     = 3;
  localparam int POS_W      = 7;
  localparam int STATUS_W   = 3;
  localparam int FOUND_W    = 6;
  localparam int COUNT_W    = 7;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int LEN_W      = $clog2(CAPACITY + 1);
  localparam int CMP_W      = (LEN_W > POS_W) ? LEN_W : POS_W;

  // Scan tree: cells are encoded in groups of eight, then the groups are picked.
  localparam int GROUP      = 8;
  localparam int GRP_W      = $clog2(GROUP);
  localparam int NUM_GROUPS = (CAPACITY + GROUP - 1) / GROUP;
  localparam int PAD_CELLS  = NUM_GROUPS * GROUP;
  localparam int GIDX_W     = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int FIDX_W     = GIDX_W + GRP_W;

  typedef enum logic [2:0] {
    KIND_PUSH_BACK  = 3'd0,
    KIND_POP_BACK   = 3'd1,
    KIND_PUSH_FRONT = 3'd2,
    KIND_POP_FRONT  = 3'd3,
    KIND_INSERT     = 3'd4,
    KIND_ERASE      = 3'd5,
    KIND_FIND       = 3'd6,
    KIND_READ       = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_FULL      = 3'd1,
    STATUS_EMPTY     = 3'd2,
    STATUS_BAD_POS   = 3'd3,
    STATUS_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_A,
    ST_SCAN_B,
    ST_SCAN_C,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_OPEN,
    CELL_CLOSE,
    CELL_SCAN
  } cell_op_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_t           op;
    logic               find;
    logic [IDX_W-1:0]   pos;
    logic [LEN_W-1:0]   len;
    logic [DATA_W-1:0]  val;
  } cell_cmd_t;

endpackage

// ===== hdl/ordered_array_list_engine_unit.sv =====
// Channel   Direction  Handshake             Word
// request   in         in_valid / in_ready   kind, position, value
// result    out        out_valid / out_ready status, found_index, read_value, count
//
// One request at a time. Push, pop, insert, erase and a failed read go from acceptance
// to the done state and then to the output register; find and a good read first pass
// through the scan states, and the done state waits while the output is stalled.
// The scan steps, in order: registered cell compare, registered group-of-eight encoder, group pick.
// Reset clears the length, the controller and the result valid; entries need no clearing.
// A stalled result does not block the next request until its own result is ready.
`include "ordered_array_list_engine_unit_defines.svh"

module ordered_array_list_engine_unit import olae_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [KIND_W-1:0]   kind,
  input  logic [POS_W-1:0]    position,
  input  logic [DATA_W-1:0]   value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [FOUND_W-1:0]  found_index,
  output logic [DATA_W-1:0]   read_value,
  output logic [COUNT_W-1:0]  count
);

  state_t state, state_next;
  logic [LEN_W-1:0] length;

  // Request held for the scan.
  logic              req_find;
  logic [IDX_W-1:0]  req_pos;
  logic [DATA_W-1:0] req_val;

  // Result waiting for the output register.
  status_t           res_status;
  logic [FOUND_W-1:0] res_found;
  logic [DATA_W-1:0] res_value;
  logic [LEN_W-1:0]  res_count;

  // Decode of the offered request.
  logic [CMP_W-1:0]  len_ext, pos_ext, ins_pos;
  cell_op_t          acc_op;
  logic [IDX_W-1:0]  acc_pos;
  logic [LEN_W-1:0]  acc_len;
  status_t           acc_status;
  logic              acc_scan;

  // Control from the state machine.
  cell_cmd_t cell_cmd;
  logic      acc_take, scan_done, out_load;

  // Chain and scan tree.
  logic [PAD_CELLS-1:0][DATA_W-1:0]  cell_data;
  logic [PAD_CELLS-1:0][DATA_W-1:0]  left_in, right_in;
  logic [PAD_CELLS-1:0]              sel_bits;
  logic [NUM_GROUPS-1:0]             grp_hit;
  logic [NUM_GROUPS-1:0][GRP_W-1:0]  grp_sub;
  logic [NUM_GROUPS-1:0][DATA_W-1:0] grp_data;
  logic                              pick_any;
  logic [FIDX_W-1:0]                 pick_idx;
  logic [DATA_W-1:0]                 pick_data;

  // Status, new length and cell command for the request on the input.
  always_comb begin
    len_ext    = CMP_W'(length);
    pos_ext    = CMP_W'(position);
    ins_pos    = pos_ext;
    acc_op     = CELL_HOLD;
    acc_pos    = '0;
    acc_len    = length;
    acc_status = STATUS_OK;
    acc_scan   = 1'b0;
    case (kind_t'(kind))
      KIND_PUSH_BACK, KIND_PUSH_FRONT, KIND_INSERT: begin
        if (kind_t'(kind) == KIND_PUSH_BACK) begin
          ins_pos = len_ext;
        end else if (kind_t'(kind) == KIND_PUSH_FRONT) begin
          ins_pos = '0;
        end
        if (ins_pos > len_ext) begin
          acc_status = STATUS_BAD_POS;
        end else if (len_ext >= CMP_W'(CAPACITY)) begin
          acc_status = STATUS_FULL;
        end else begin
          acc_op  = CELL_OPEN;
          acc_pos = ins_pos[IDX_W-1:0];
          acc_len = length + LEN_W'(1);
        end
      end
      KIND_POP_BACK: begin
        if (length == '0) begin
          acc_status = STATUS_EMPTY;
        end else begin
          acc_len = length - LEN_W'(1);
        end
      end
      KIND_POP_FRONT: begin
        if (length == '0) begin
          acc_status = STATUS_EMPTY;
        end else begin
          acc_op  = CELL_CLOSE;
          acc_pos = '0;
          acc_len = length - LEN_W'(1);
        end
      end
      KIND_ERASE: begin
        if (pos_ext >= len_ext) begin
          acc_status = STATUS_BAD_POS;
        end else begin
          acc_op  = CELL_CLOSE;
          acc_pos = pos_ext[IDX_W-1:0];
          acc_len = length - LEN_W'(1);
        end
      end
      KIND_FIND: begin
        acc_scan = 1'b1;
      end
      KIND_READ: begin
        if (pos_ext >= len_ext) begin
          acc_status = STATUS_BAD_POS;
        end else begin
          acc_scan = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = acc_scan ? ST_SCAN_A : ST_DONE;
        end
      end
      ST_SCAN_A: state_next = ST_SCAN_B;
      ST_SCAN_B: state_next = ST_SCAN_C;
      ST_SCAN_C: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State machine outputs.
  always_comb begin
    in_ready  = 1'b0;
    acc_take  = 1'b0;
    scan_done = 1'b0;
    out_load  = 1'b0;
    cell_cmd  = '0;
    cell_cmd.op = CELL_HOLD;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        acc_take = in_valid;
        if (in_valid) begin
          cell_cmd.op  = acc_op;
          cell_cmd.pos = acc_pos;
          cell_cmd.val = value;
        end
      end
      ST_SCAN_A: begin
        cell_cmd.op   = CELL_SCAN;
        cell_cmd.find = req_find;
        cell_cmd.pos  = req_pos;
        cell_cmd.len  = length;
        cell_cmd.val  = req_val;
      end
      ST_SCAN_C: scan_done = 1'b1;
      ST_DONE:   out_load  = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
    end else if (acc_take) begin
      length <= acc_len;
    end
  end

  // Request and result registers.
  always_ff @(posedge clk) begin
    if (acc_take) begin
      req_find   <= (kind_t'(kind) == KIND_FIND);
      req_pos    <= pos_ext[IDX_W-1:0];
      req_val    <= value;
      res_status <= acc_status;
      res_found  <= '0;
      res_value  <= '0;
      res_count  <= acc_len;
    end else if (scan_done) begin
      if (req_find) begin
        res_status <= pick_any ? STATUS_OK : STATUS_NOT_FOUND;
        res_found  <= pick_any ? FOUND_W'(pick_idx) : '0;
      end else begin
        res_value <= pick_data;
      end
    end
  end

  // Output register: the result word waits here while a new request is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= STATUS_W'(res_status);
      found_index <= res_found;
      read_value  <= res_value;
      count       <= COUNT_W'(res_count);
    end
  end

  // Chain of cells; cells past the capacity only pad the last group.
  for (genvar i = 0; i < PAD_CELLS; i++) begin : g_cell
    if (i < CAPACITY) begin : g_live
      if (i == 0) begin : g_first
        assign left_in[i] = '0;
      end else begin : g_mid
        assign left_in[i] = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_in[i] = cell_data[i];
      end else begin : g_inner
        assign right_in[i] = cell_data[i+1];
      end
      olae_cell u_cell (
        .clk        (clk),
        .cmd        (cell_cmd),
        .index      (IDX_W'(i)),
        .left_data  (left_in[i]),
        .right_data (right_in[i]),
        .entry      (cell_data[i]),
        .sel        (sel_bits[i])
      );
    end else begin : g_pad
      assign left_in[i]   = '0;
      assign right_in[i]  = '0;
      assign cell_data[i] = '0;
      assign sel_bits[i]  = 1'b0;
    end
  end

  // First level of the scan tree.
  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
    olae_group u_group (
      .clk       (clk),
      .sel       (sel_bits[g*GROUP +: GROUP]),
      .data      (cell_data[g*GROUP +: GROUP]),
      .hit       (grp_hit[g]),
      .sub       (grp_sub[g]),
      .pick_data (grp_data[g])
    );
  end

  // Second level: the lowest group with a hit gives index and data.
  always_comb begin
    pick_any  = |grp_hit;
    pick_idx  = '0;
    pick_data = '0;
    for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
      if (grp_hit[g]) begin
        pick_idx  = {GIDX_W'(g), grp_sub[g]};
        pick_data = grp_data[g];
      end
    end
  end

  `OLAE_ASSERT_HOLDS(a_len_cap, length <= LEN_W'(CAPACITY), "list length beyond capacity")
  `OLAE_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request taken while busy")
  `OLAE_ASSERT_NEXT(a_out_load, state == ST_DONE && (!out_valid || out_ready), out_valid && in_ready, "result not moved to output")
  `OLAE_ASSERT_NEXT(a_len_step, in_valid && in_ready && length == '0, length <= LEN_W'(1), "length jumped from empty")

endmodule

// ===== hdl/olae_cell.sv =====
module olae_cell import olae_pkg::*; (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [IDX_W-1:0]  index,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] entry,
  output logic              sel
);

  // Open a gap, close a gap or flag this cell for the scan tree.
  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_OPEN: begin
        if (index == cmd.pos) begin
          entry <= cmd.val;
        end else if (index > cmd.pos) begin
          entry <= left_data;
        end
      end
      CELL_CLOSE: begin
        if (index >= cmd.pos) begin
          entry <= right_data;
        end
      end
      CELL_SCAN: begin
        if (cmd.find) begin
          sel <= (entry == cmd.val) && (LEN_W'(index) < cmd.len);
        end else begin
          sel <= (index == cmd.pos);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/olae_group.sv =====
module olae_group import olae_pkg::*; (
  input  logic                         clk,
  input  logic [GROUP-1:0]             sel,
  input  logic [GROUP-1:0][DATA_W-1:0] data,
  output logic                         hit,
  output logic [GRP_W-1:0]             sub,
  output logic [DATA_W-1:0]            pick_data
);

  logic              hit_next;
  logic [GRP_W-1:0]  sub_next;
  logic [DATA_W-1:0] pick_data_next;

  // The lowest flagged cell of the group wins.
  always_comb begin
    hit_next       = |sel;
    sub_next       = '0;
    pick_data_next = '0;
    for (int k = GROUP - 1; k >= 0; k--) begin
      if (sel[k]) begin
        sub_next       = GRP_W'(k);
        pick_data_next = data[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    hit       <= hit_next;
    sub       <= sub_next;
    pick_data <= pick_data_next;
  end

endmodule

// ===== sim/ordered_array_list_engine_unit_tb.sv =====
module ordered_array_list_engine_unit_tb import olae_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int QUIET_TAIL     = 120;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_ITEMS   = 1100;

  typedef struct packed {
    kind_t              kind;
    logic [POS_W-1:0]   position;
    logic [DATA_W-1:0]  value;
  } list_request_t;

  typedef struct packed {
    status_t              status;
    logic [FOUND_W-1:0]   found_index;
    logic [DATA_W-1:0]    read_value;
    logic [COUNT_W-1:0]   count;
  } list_result_t;

  typedef enum {FILL_UP, CHURN, DRAIN} load_mode_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [KIND_W-1:0]   kind = '0;
  logic [POS_W-1:0]    position = '0;
  logic [DATA_W-1:0]   value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [FOUND_W-1:0]  found_index;
  logic [DATA_W-1:0]   read_value;
  logic [COUNT_W-1:0]  count;

  // Words waiting to be sent, and results owed by the block, oldest first.
  list_request_t pending_requests [$];
  list_result_t  expected_results [$];

  // Mirror of the list contents and length as the block should hold them.
  logic [DATA_W-1:0] list_cells [CAPACITY];
  int                list_len;

  // Length the stimulus planner assumes while it builds the request queue.
  int plan_len;

  int words_offered;
  int words_accepted;
  int results_taken;
  int send_gap;
  int recv_stall;
  int idle_cycles;
  int error_count;
  int peak_len;
  int kinds_taken [8];
  int outcomes [5];

  ordered_array_list_engine_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .position    (position),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .found_index (found_index),
    .read_value  (read_value),
    .count       (count)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Apply one request to the mirrored list and return the result it owes.
  function automatic list_result_t apply_list_request(list_request_t req);
    list_result_t res;
    int           at;
    bit           hit;
    res.status      = STATUS_OK;
    res.found_index = '0;
    res.read_value  = '0;
    hit             = 1'b0;
    case (req.kind)
      KIND_PUSH_BACK, KIND_PUSH_FRONT, KIND_INSERT: begin
        if (req.kind == KIND_PUSH_BACK) begin
          at = list_len;
        end else if (req.kind == KIND_PUSH_FRONT) begin
          at = 0;
        end else begin
          at = int'(req.position);
        end
        // The position check takes priority over the full check.
        if (at > list_len) begin
          res.status = STATUS_BAD_POS;
        end else if (list_len >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          for (int k = list_len; k > at; k--) list_cells[k] = list_cells[k-1];
          list_cells[at] = req.value;
          list_len++;
        end
      end
      KIND_POP_BACK: begin
        if (list_len == 0) res.status = STATUS_EMPTY;
        else list_len--;
      end
      KIND_POP_FRONT, KIND_ERASE: begin
        at = (req.kind == KIND_POP_FRONT) ? 0 : int'(req.position);
        if (req.kind == KIND_POP_FRONT && list_len == 0) begin
          res.status = STATUS_EMPTY;
        end else if (at >= list_len) begin
          res.status = STATUS_BAD_POS;
        end else begin
          for (int k = at + 1; k < list_len; k++) list_cells[k-1] = list_cells[k];
          list_len--;
        end
      end
      KIND_FIND: begin
        res.status = STATUS_NOT_FOUND;
        for (int k = 0; k < list_len; k++) begin
          if (!hit && list_cells[k] == req.value) begin
            hit             = 1'b1;
            res.status      = STATUS_OK;
            res.found_index = FOUND_W'(k);
          end
        end
      end
      default: begin
        if (int'(req.position) >= list_len) res.status = STATUS_BAD_POS;
        else res.read_value = list_cells[req.position];
      end
    endcase
    res.count = COUNT_W'(list_len);
    if (list_len > peak_len) peak_len = list_len;
    return res;
  endfunction

  // Length after a request, used only to steer positions in the stimulus.
  function automatic int length_after(kind_t k, int pos, int len);
    case (k)
      KIND_PUSH_BACK, KIND_PUSH_FRONT: return (len < CAPACITY) ? len + 1 : len;
      KIND_INSERT:                     return (pos <= len && len < CAPACITY) ? len + 1 : len;
      KIND_POP_BACK, KIND_POP_FRONT:   return (len > 0) ? len - 1 : len;
      KIND_ERASE:                      return (pos < len) ? len - 1 : len;
      default:                         return len;
    endcase
  endfunction

  task automatic queue_request(kind_t k, int pos, logic [DATA_W-1:0] v);
    list_request_t req;
    req.kind     = k;
    req.position = POS_W'(pos);
    req.value    = v;
    pending_requests.push_back(req);
    plan_len = length_after(k, pos, plan_len);
  endtask

  // Values lean on a small pool so that finds hit often.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return DATA_W'($urandom_range(0, 7));
      4: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'hffff_ffff;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic kind_t pick_kind(load_mode_t mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      FILL_UP: begin
        if (r < 30)      return KIND_PUSH_BACK;
        else if (r < 50) return KIND_PUSH_FRONT;
        else if (r < 70) return KIND_INSERT;
        else if (r < 78) return KIND_FIND;
        else if (r < 86) return KIND_READ;
        else if (r < 90) return KIND_POP_BACK;
        else if (r < 94) return KIND_POP_FRONT;
        else             return KIND_ERASE;
      end
      DRAIN: begin
        if (r < 25)      return KIND_POP_BACK;
        else if (r < 45) return KIND_POP_FRONT;
        else if (r < 70) return KIND_ERASE;
        else if (r < 80) return KIND_FIND;
        else if (r < 90) return KIND_READ;
        else if (r < 94) return KIND_PUSH_BACK;
        else if (r < 97) return KIND_PUSH_FRONT;
        else             return KIND_INSERT;
      end
      default: return kind_t'($urandom_range(0, 7));
    endcase
  endfunction

  // Positions are mostly legal for the planned length, sometimes anywhere in range.
  function automatic int pick_position(kind_t k);
    if ($urandom_range(0, 99) < 85) begin
      if (k == KIND_INSERT) return $urandom_range(0, plan_len);
      if ((k == KIND_ERASE || k == KIND_READ) && plan_len > 0) return $urandom_range(0, plan_len - 1);
    end
    return $urandom_range(0, CAPACITY);
  endfunction

  function automatic void note_failure(string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR: %s", msg);
  endfunction

  // Driver: offer the next word at the falling edge once the last one was taken.
  always @(negedge clk) begin : drive_requests
    list_request_t req;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && words_accepted != words_offered)) begin
      if (send_gap > 0 && pending_requests.size() >= QUIET_TAIL) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_requests.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        send_gap <= $urandom_range(0, 9);
        in_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        req = pending_requests.pop_front();
        kind          <= req.kind;
        position      <= req.position;
        value         <= req.value;
        in_valid      <= 1'b1;
        words_offered <= words_offered + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver backpressure in random bursts, none near the end.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (pending_requests.size() < QUIET_TAIL) begin
      out_ready <= 1'b1;
    end else if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      recv_stall <= $urandom_range(0, 9);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every accepted word updates the mirror and queues the result it owes.
  always @(posedge clk) begin : take_requests
    list_request_t req;
    list_result_t  res;
    if (!rst && in_valid && in_ready) begin
      req.kind     = kind_t'(kind);
      req.position = position;
      req.value    = value;
      res = apply_list_request(req);
      expected_results.push_back(res);
      kinds_taken[kind]++;
      outcomes[res.status]++;
      words_accepted <= words_accepted + 1;
    end
  end

  // Monitor: each result word is checked against the oldest expectation.
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_taken <= results_taken + 1;
      if (expected_results.size() == 0) begin
        note_failure($sformatf("result word with nothing expected: status %0d count %0d",
                               status, count));
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status)
          note_failure($sformatf("status: expected %0d, got %0d", want.status, status));
        if (found_index !== want.found_index)
          note_failure($sformatf("found_index: expected %0d, got %0d",
                                 want.found_index, found_index));
        if (read_value !== want.read_value)
          note_failure($sformatf("read_value: expected %h, got %h", want.read_value, read_value));
        if (count !== want.count)
          note_failure($sformatf("count: expected %0d, got %0d", want.count, count));
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    load_mode_t mode;
    int         seg_left;
    kind_t      k;

    plan_len = 0;

    // Empty list: pops report empty, position checks fail, find misses.
    queue_request(KIND_POP_BACK,  0, 32'h0);
    queue_request(KIND_POP_FRONT, 0, 32'h0);
    queue_request(KIND_ERASE,     0, 32'h0);
    queue_request(KIND_READ,      0, 32'h0);
    queue_request(KIND_FIND,      0, 32'h0);
    queue_request(KIND_INSERT,    1, 32'h5);
    // Build a short list with extreme values at the ends and in the middle.
    queue_request(KIND_PUSH_BACK,  0, 32'h7fff_ffff);
    queue_request(KIND_PUSH_FRONT, 0, 32'h8000_0000);
    queue_request(KIND_INSERT,     1, 32'hffff_ffff);
    queue_request(KIND_INSERT,     3, 32'h0000_0000);
    queue_request(KIND_INSERT,     CAPACITY, 32'h1);
    queue_request(KIND_READ,       0, 32'h0);
    queue_request(KIND_READ,       3, 32'h0);
    queue_request(KIND_READ,       4, 32'h0);
    queue_request(KIND_READ,       CAPACITY, 32'h0);
    queue_request(KIND_FIND,       0, 32'hffff_ffff);
    queue_request(KIND_FIND,       0, 32'h1234_5678);
    // A duplicate value: find returns the first match.
    queue_request(KIND_PUSH_BACK,  0, 32'h7fff_ffff);
    queue_request(KIND_FIND,       0, 32'h7fff_ffff);
    queue_request(KIND_ERASE,      1, 32'h0);
    queue_request(KIND_ERASE,      4, 32'h0);
    queue_request(KIND_POP_FRONT,  0, 32'h0);
    queue_request(KIND_POP_BACK,   0, 32'h0);
    queue_request(KIND_ERASE,      63, 32'h0);
    queue_request(KIND_READ,       1, 32'h0);

    // Random traffic in segments that fill the list, churn it and drain it.
    mode     = FILL_UP;
    seg_left = 180;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (seg_left == 0) begin
        case (mode)
          FILL_UP: mode = CHURN;
          CHURN:   mode = DRAIN;
          default: mode = FILL_UP;
        endcase
        seg_left = $urandom_range(100, 170);
      end
      seg_left--;
      k = pick_kind(mode);
      queue_request(k, pick_position(k), pick_value());
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || words_accepted != words_offered) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_results.size()));

    $display("Covered %0d requests: push back %0d, pop back %0d, push front %0d, pop front %0d,",
             words_accepted, kinds_taken[KIND_PUSH_BACK], kinds_taken[KIND_POP_BACK],
             kinds_taken[KIND_PUSH_FRONT], kinds_taken[KIND_POP_FRONT]);
    $display("  insert %0d, erase %0d, find %0d, read %0d; ok %0d full %0d empty %0d bad %0d miss %0d, peak length %0d",
             kinds_taken[KIND_INSERT], kinds_taken[KIND_ERASE], kinds_taken[KIND_FIND],
             kinds_taken[KIND_READ], outcomes[STATUS_OK], outcomes[STATUS_FULL],
             outcomes[STATUS_EMPTY], outcomes[STATUS_BAD_POS], outcomes[STATUS_NOT_FOUND],
             peak_len);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("Mismatches: %0d", error_count);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
